FILE: hdl/sid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sid_pkg: shared types for the sorted insert deque
// Operation and status codes, and the control word broadcast to every cell.
// ----------------------------------------------------------------------------
package sid_pkg;

    // Operation codes carried by an input item.
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SORTED     = 3'd4
    } op_t;

    // Status codes returned with each result item.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // What every cell does in the current cycle.
    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_INSERT    = 2'd1,
        CELL_POP_FRONT = 2'd2
    } cell_mode_t;

    // Control word that the top level broadcasts to the row of cells.
    typedef struct packed {
        cell_mode_t         mode;
        logic               force_ge;
        logic               cmp_en;
        logic signed [31:0] value;
    } cell_ctrl_t;

endpackage

FILE: hdl/sid_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sid_cell: one entry of the sorted insert deque
// Holds one value, decides locally whether it is the insert point, and
// shifts toward the back on an insert or toward the front on a front pop.
// ----------------------------------------------------------------------------
module sid_cell
    import sid_pkg::*;
(
    input  logic               clk,
    input  cell_ctrl_t         ctrl,
    input  logic               valid,
    input  logic               next_valid,
    input  logic signed [31:0] left_value,
    input  logic signed [31:0] right_value,
    input  logic               found_in,
    output logic               found_out,
    input  logic signed [31:0] back_in,
    output logic signed [31:0] back_out,
    output logic signed [31:0] value
);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic               ge;

    // An empty cell always qualifies as the insert point, so a push at the
    // back and a sorted insert past every entry land on the first free cell.
    assign ge = ctrl.force_ge | ~valid | (ctrl.cmp_en & (value_reg >= ctrl.value));
    assign found_out = found_in | ge;

    // The last held entry places its value on the back chain.
    assign back_out = (valid & ~next_valid) ? value_reg : back_in;
    assign value = value_reg;

    // Next value: take the left neighbor behind the insert point, the new
    // value at it, or the right neighbor on a front pop.
    always_comb
    begin
        value_next = value_reg;
        case (ctrl.mode)
            CELL_INSERT:
            begin
                if (found_in)
                begin
                    value_next = left_value;
                end
                else if (ge)
                begin
                    value_next = ctrl.value;
                end
            end
            CELL_POP_FRONT:
            begin
                value_next = right_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    // Entry storage, undefined until written.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

FILE: hdl/sorted_insert_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_deque: bounded deque of signed Q16.16 values with sorted insert
// A row of DEPTH cells holds the entries, front at cell 0. Each operation
// updates every cell in the same cycle.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Fields
//  -------   ---------          ------
//  input     start, busy        op, value_in
//  result    done (strobe)      value_out, status, occupancy
//
//  An item is taken at every clock edge where start is high and busy is low;
//  busy stays low, so one item is taken per cycle.
//  The result is on the result ports in the cycle after acceptance.
//  The cycle time is set by the insert-point chain and the back-value chain,
//  which ripple through the row of cells.
//  Reset clears the entry count and the result strobe only; entries need no clearing pass.
//  The receiver cannot stall, so results are never held.
//
module sorted_insert_deque
    import sid_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         op,
    input  logic signed [31:0] value_in,
    output logic               done,
    output logic signed [31:0] value_out,
    output logic [1:0]         status,
    output logic [4:0]         occupancy
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               done_reg;
    logic signed [31:0] value_out_reg;
    logic signed [31:0] value_out_next;
    status_t            status_reg;
    status_t            status_next;
    logic [4:0]         occupancy_reg;
    cell_ctrl_t         ctrl;
    logic               accept;
    logic               full;
    logic               empty;

    logic signed [31:0] cell_value [DEPTH];
    logic signed [31:0] back_chain [DEPTH+1];
    logic               found_chain [DEPTH+1];
    logic               cell_valid [DEPTH+1];

    assign busy   = 1'b0;
    assign accept = start & ~busy;
    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);

    // Decode the operation into the cell control word and the result.
    always_comb
    begin
        ctrl.mode      = CELL_HOLD;
        ctrl.force_ge  = 1'b0;
        ctrl.cmp_en    = 1'b0;
        ctrl.value     = value_in;
        count_next     = count_reg;
        value_out_next = '0;
        status_next    = ST_OK;
        case (op_t'(op))
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_SORTED:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctrl.mode     = CELL_INSERT;
                    ctrl.force_ge = (op_t'(op) == OP_PUSH_FRONT);
                    ctrl.cmp_en   = (op_t'(op) == OP_SORTED);
                    count_next    = count_reg + 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    ctrl.mode      = CELL_POP_FRONT;
                    value_out_next = cell_value[0];
                    count_next     = count_reg - 1'b1;
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    value_out_next = back_chain[0];
                    count_next     = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        if (!accept)
        begin
            ctrl.mode  = CELL_HOLD;
            count_next = count_reg;
        end
    end

    // Chain ends: nothing is found before cell 0, and nothing lies past the back.
    assign found_chain[0]     = 1'b0;
    assign back_chain[DEPTH]  = '0;
    assign cell_valid[DEPTH]  = 1'b0;

    // The row of cells.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [31:0] left_value;
        logic signed [31:0] right_value;

        assign cell_valid[i] = (CW'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign left_value = ctrl.value;
        end
        else
        begin : g_inner_left
            assign left_value = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_value = cell_value[i];
        end
        else
        begin : g_inner_right
            assign right_value = cell_value[i+1];
        end

        sid_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .valid       (cell_valid[i]),
            .next_valid  (cell_valid[i+1]),
            .left_value  (left_value),
            .right_value (right_value),
            .found_in    (found_chain[i]),
            .found_out   (found_chain[i+1]),
            .back_in     (back_chain[i+1]),
            .back_out    (back_chain[i]),
            .value       (cell_value[i])
        );
    end

    // Entry count and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_out_reg <= value_out_next;
            status_reg    <= status_next;
            occupancy_reg <= 5'(count_next);
        end
    end

    assign done      = done_reg;
    assign value_out = value_out_reg;
    assign status    = status_reg;
    assign occupancy = occupancy_reg;

`ifndef SYNTHESIS
    // Every accepted item gives exactly one result in the next cycle.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result strobe missing after an accepted item");
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result strobe without an accepted item");
    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond capacity");
    // A full error leaves the store at capacity.
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (occupancy == 5'(DEPTH)))
        else $error("full error with store below capacity");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sorted_insert_deque
// Feeds push, pop, sorted insert and unused-code items in random bursts, predicts every
// result with a behavioral deque model and checks each strobed result.
// ----------------------------------------------------------------------------
module testbench;
    import sid_pkg::*;

    localparam int DEPTH        = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_COUNT  = 12;
    localparam int PHASE_ITEMS  = 120;
    localparam int REPORT_LIMIT = 10;

    // Op codes that the block ignores.
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    // Bias of a random phase.
    localparam int BIAS_FILL  = 0;
    localparam int BIAS_DRAIN = 1;
    localparam int BIAS_MIXED = 2;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct {
        logic [2:0]         code;
        logic signed [31:0] val;
    } deque_cmd_t;

    typedef struct {
        logic signed [31:0] value;
        status_t            status;
        logic [4:0]         occupancy;
    } deque_result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         op;
    logic signed [31:0] value_in;
    logic               done;
    logic signed [31:0] value_out;
    logic [1:0]         status;
    logic [4:0]         occupancy;

    // Items waiting to be driven and results waiting to arrive.
    deque_cmd_t    pending_cmds[$];
    deque_result_t expected_results[$];

    // Shadow copy of the deque contents.
    logic signed [31:0] model_entries [DEPTH];
    int                 model_count;

    logic cmd_taken;
    int   burst_left;
    int   gap_left;
    int   fail_count;
    int   cycle_count;
    int   result_count;
    int   full_hits;
    int   empty_hits;
    int   sorted_count;
    int   peak_occupancy;

    sorted_insert_deque #(.DEPTH(DEPTH)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .value_in  (value_in),
        .done      (done),
        .value_out (value_out),
        .status    (status),
        .occupancy (occupancy)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Applies one operation to the shadow deque and returns its result.
    function automatic deque_result_t apply_deque_op(logic [2:0] code, logic signed [31:0] val);
        deque_result_t r;
        int            pos;
        bit            found;
        r.value  = '0;
        r.status = ST_OK;
        case (code)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_SORTED:
            begin
                if (model_count >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    pos = model_count;
                    if (code == OP_PUSH_FRONT)
                    begin
                        pos = 0;
                    end
                    else if (code == OP_SORTED)
                    begin
                        // Go before the first entry that is not smaller.
                        sorted_count++;
                        found = 1'b0;
                        for (int i = 0; i < model_count; i++)
                        begin
                            if (!found && model_entries[i] >= val)
                            begin
                                pos   = i;
                                found = 1'b1;
                            end
                        end
                    end
                    for (int i = model_count; i > pos; i--)
                    begin
                        model_entries[i] = model_entries[i - 1];
                    end
                    model_entries[pos] = val;
                    model_count++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (model_count == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else if (code == OP_POP_FRONT)
                begin
                    r.value = model_entries[0];
                    for (int i = 1; i < model_count; i++)
                    begin
                        model_entries[i - 1] = model_entries[i];
                    end
                    model_count--;
                end
                else
                begin
                    r.value = model_entries[model_count - 1];
                    model_count--;
                end
            end
            default:
            begin
                // Unused codes leave the deque alone.
            end
        endcase
        r.occupancy = model_count[4:0];
        return r;
    endfunction

    // Values: mostly full random, some from a small pool so equal keys meet.
    function automatic logic signed [31:0] pick_value();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 6)
        begin
            return $urandom;
        end
        else if (kind < 9)
        begin
            return ($urandom_range(0, 6) - 3) <<< 16;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: return Q_MAX;
                1: return Q_MIN;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
    endfunction

    // Chooses an op code according to the bias of the phase.
    function automatic logic [2:0] pick_op(int bias);
        int r;
        int pop_share;
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            return 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
        case (bias)
            BIAS_FILL:  pop_share = 20;
            BIAS_DRAIN: pop_share = 65;
            BIAS_MIXED: pop_share = 45;
            default:    pop_share = 45;
        endcase
        if (r < 3 + pop_share)
        begin
            return ($urandom_range(0, 1) == 0) ? OP_POP_FRONT : OP_POP_BACK;
        end
        case ($urandom_range(0, 3))
            0: return OP_PUSH_FRONT;
            1: return OP_PUSH_BACK;
            default: return OP_SORTED;
        endcase
    endfunction

    task automatic queue_cmd(logic [2:0] code, logic signed [31:0] val);
        deque_cmd_t c;
        c.code = code;
        c.val  = val;
        pending_cmds.push_back(c);
    endtask

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Holds the sender back until every item is driven and every result is in.
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Driver: presents queued items in bursts separated by random gaps.
    always @(negedge clk)
    begin : driver
        if (rst_n)
        begin
            if (cmd_taken && pending_cmds.size() > 0)
            begin
                void'(pending_cmds.pop_front());
            end
            if (start && !cmd_taken)
            begin
                // The block held the item off; keep it on the ports.
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                start    <= 1'b1;
                op       <= pending_cmds[0].code;
                value_in <= pending_cmds[0].val;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks strobed results, then records newly accepted items.
    always @(posedge clk)
    begin : monitor
        deque_result_t want;
        if (!rst_n)
        begin
            cmd_taken <= 1'b0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    note_failure($sformatf("result with nothing expected: value %0d status %0d",
                                           value_out, status));
                end
                else
                begin
                    want = expected_results.pop_front();
                    result_count++;
                    if (want.status == ST_FULL)
                        full_hits++;
                    if (want.status == ST_EMPTY)
                        empty_hits++;
                    if (int'(want.occupancy) > peak_occupancy)
                        peak_occupancy = int'(want.occupancy);
                    if (value_out !== want.value || status !== want.status ||
                        occupancy !== want.occupancy)
                    begin
                        note_failure($sformatf(
                            "value %0d/%0d status %0d/%0d occupancy %0d/%0d (want/got)",
                            want.value, value_out, want.status, status,
                            want.occupancy, occupancy));
                    end
                end
            end
            cmd_taken <= start && !busy;
            if (start && !busy)
            begin
                expected_results.push_back(apply_deque_op(op, value_in));
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int bias;
        rst_n          = 1'b0;
        start          = 1'b0;
        op             = OP_PUSH_FRONT;
        value_in       = '0;
        model_count    = 0;
        burst_left     = 1;
        gap_left       = 0;
        fail_count     = 0;
        cycle_count    = 0;
        result_count   = 0;
        full_hits      = 0;
        empty_hits     = 0;
        sorted_count   = 0;
        peak_occupancy = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: empty pops, extremes, equal keys, unused codes.
        queue_cmd(OP_POP_FRONT, $urandom);
        queue_cmd(OP_POP_BACK, $urandom);
        queue_cmd(OP_SORTED, 32'sh1234_0000);
        queue_cmd(OP_SORTED, 32'sh1234_0000);
        queue_cmd(OP_PUSH_FRONT, Q_MAX);
        queue_cmd(OP_PUSH_BACK, Q_MIN);
        queue_cmd(OP_SORTED, Q_MIN);
        queue_cmd(OP_SORTED, Q_MAX);
        queue_cmd(OP_SORTED, -32'sd1);
        queue_cmd(OP_UNUSED_LO, $urandom);
        queue_cmd(OP_UNUSED_LO + 3'd1, $urandom);
        queue_cmd(OP_UNUSED_HI, $urandom);
        for (int i = 0; i < 8; i++)
        begin
            queue_cmd((i % 2 == 0) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
        end
        wait_drained();

        // Random phases that alternately fill, drain and churn the deque.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            bias = p % 3;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                queue_cmd(pick_op(bias), pick_value());
            end
            if (p % 4 == 3)
            begin
                wait_drained();
            end
        end
        wait_drained();
        repeat (4) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            note_failure($sformatf("%0d results never arrived", expected_results.size()));
        end
        $display("Checked %0d results: %0d sorted inserts, %0d full and %0d empty errors,",
                 result_count, sorted_count, full_hits, empty_hits);
        $display("peak occupancy %0d of %0d, %0d failures.", peak_occupancy, DEPTH, fail_count);
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: sorted_insert_deque.f
hdl/sid_pkg.sv
hdl/sid_cell.sv
hdl/sorted_insert_deque.sv
verif/testbench.sv
